FILE: sv/lpd_pkg.sv
// Shared types and constants for the pinned page directory.
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int PAGE_W   = 32;
    localparam int STAMP_W  = 32;
    localparam int PIN_W    = 16;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;

    localparam logic [PIN_W-1:0]   PIN_MAX   = '1;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_GET   = 2'd0,
        FN_UNPIN = 2'd1,
        FN_DIRTY = 2'd2,
        FN_FLUSH = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 3'd0,
        ST_MISS   = 3'd1,
        ST_PINNED = 3'd2,
        ST_DONE   = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    // One slot as held in the directory memory.
    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
        logic [PIN_W-1:0]   pins;
    } entry_t;

endpackage

FILE: sv/lpd_if.sv
// Request and response channel interfaces of the pinned page directory.
`timescale 1ns / 1ps

interface lpd_req_if;
    import lpd_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [PAGE_W-1:0]   page_id;

    modport source  (output valid, output func, output page_id, input ready);
    modport sink    (input valid, input func, input page_id, output ready);
    modport monitor (input valid, input func, input page_id, input ready);
endinterface

interface lpd_rsp_if;
    import lpd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  slot_index;
    logic                fetch_valid;
    logic                writeback_valid;
    logic [PAGE_W-1:0]   writeback_id;
    logic [PIN_W-1:0]    pins_now;

    modport source (
        output valid, output status, output slot_index, output fetch_valid,
        output writeback_valid, output writeback_id, output pins_now, input ready
    );
    modport sink (
        input valid, input status, input slot_index, input fetch_valid,
        input writeback_valid, input writeback_id, input pins_now, output ready
    );
    modport monitor (
        input valid, input status, input slot_index, input fetch_valid,
        input writeback_valid, input writeback_id, input pins_now, input ready
    );
endinterface

FILE: sv/lru_pinned_page_directory_top.sv
// Top level of the pinned page directory with least-recently-used replacement.
// An accepted item is scanned against every slot, then decided into the result register.
// One item is in work at a time: the scan reads one slot a cycle through the single read port
// of the slot memory and feeds one shared match and stamp comparator, and a result left waiting
// holds the next item in its decision.
// Reset (rst_n, asynchronous, active low) clears the control state, the valid and dirty bits,
// the stamp counter and the occupancy count; the slot memory needs no clearing pass.
`timescale 1ns / 1ps

module lru_pinned_page_directory_top #(
    parameter int SLOTS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lpd_req_if.sink   req,
    lpd_rsp_if.source rsp
);
    import lpd_pkg::*;

    // Index width into the slots, and a counter width that can also hold SLOTS itself.
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // Sequencer state.
    state_t state_reg, state_next;

    // Latched request.
    func_t              func_reg;
    logic [PAGE_W-1:0]  page_reg;

    // Slot memory: page id, access stamp and pin count of every slot. An entry's contents are only
    // used once its valid bit is set, so the memory carries no reset.
    entry_t             entry_mem [SLOTS];
    entry_t             rd_data_reg;

    // Scan pipeline: issue counter, then the registered read and its slot number.
    logic [CW-1:0]      issue_cnt_reg;
    logic               rd_valid_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic               issue;
    logic [IW-1:0]      rd_addr;

    // What the scan has found so far.
    logic               found_reg, found_next;
    logic [IW-1:0]      hit_idx_reg, hit_idx_next;
    entry_t             hit_entry_reg, hit_entry_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               vic_found_reg, vic_found_next;
    logic [IW-1:0]      vic_idx_reg, vic_idx_next;
    entry_t             vic_entry_reg, vic_entry_next;

    // Per-slot flags and global counters.
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [SLOTS-1:0]   dirty_reg, dirty_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [CW-1:0]      occ_reg, occ_next;

    // Decision and memory write.
    logic               accept;
    logic               do_load;
    logic               commit;
    logic               wr_en;
    logic [IW-1:0]      wr_idx;
    entry_t             wr_entry;
    logic               take_stamp;
    logic               install;
    logic [IW-1:0]      inst_idx;
    logic [PIN_W-1:0]   pins_inc;
    logic [PIN_W-1:0]   pins_dec;

    // Result being formed, and the result register that holds it until it is taken.
    status_t            res_status;
    logic [IW-1:0]      res_slot;
    logic               res_fetch;
    logic               res_wb;
    logic [PAGE_W-1:0]  res_wb_id;
    logic [PIN_W-1:0]   res_pins;

    logic               rsp_valid_reg;
    status_t            rsp_status_reg;
    logic [IW-1:0]      rsp_slot_reg;
    logic               rsp_fetch_reg;
    logic               rsp_wb_reg;
    logic [PAGE_W-1:0]  rsp_wb_id_reg;
    logic [PIN_W-1:0]   rsp_pins_reg;

    // A new item is taken whenever the sequencer is idle, even while the previous result
    // still waits in the result register.
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // The result register may be loaded when it is empty or is being emptied this cycle.
    assign do_load = !rsp_valid_reg || rsp.ready;
    assign commit  = (state_reg == S_DECIDE) && do_load;

    assign issue   = (state_reg == S_SCAN) && (issue_cnt_reg != CW'(SLOTS));
    assign rd_addr = issue_cnt_reg[IW-1:0];

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Done once every slot has been issued and the last read compared.
                if (!issue && !rd_valid_reg)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (do_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Shared compare unit: one slot a cycle is checked for a page match, for being free, and
    // against the oldest unpinned slot found so far. Scanning in ascending order with strict
    // comparisons lets the lowest index win every tie.
    always_comb
    begin
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_entry_next  = hit_entry_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_entry_next  = vic_entry_reg;
        if (rd_valid_reg)
        begin
            if (valid_reg[rd_idx_reg])
            begin
                if (!found_reg && (rd_data_reg.page == page_reg))
                begin
                    found_next     = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_entry_next = rd_data_reg;
                end
                if ((rd_data_reg.pins == '0) &&
                    (!vic_found_reg || (rd_data_reg.stamp < vic_entry_reg.stamp)))
                begin
                    vic_found_next = 1'b1;
                    vic_idx_next   = rd_idx_reg;
                    vic_entry_next = rd_data_reg;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
        end
    end

    assign pins_inc = (hit_entry_reg.pins == PIN_MAX) ? hit_entry_reg.pins
                                                      : hit_entry_reg.pins + 1'b1;
    assign pins_dec = (hit_entry_reg.pins == '0) ? hit_entry_reg.pins
                                                 : hit_entry_reg.pins - 1'b1;

    // Decision on the scanned slots: the result, the slot write and the flag updates.
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        stamp_next = stamp_reg;
        occ_next   = occ_reg;
        wr_en      = 1'b0;
        wr_idx     = hit_idx_reg;
        wr_entry   = hit_entry_reg;
        take_stamp = 1'b0;
        install    = 1'b0;
        inst_idx   = free_idx_reg;
        res_status = ST_ABSENT;
        res_slot   = '0;
        res_fetch  = 1'b0;
        res_wb     = 1'b0;
        res_wb_id  = '0;
        res_pins   = '0;

        if (func_reg == FN_GET)
        begin
            if (found_reg)
            begin
                // Hit: refresh the stamp and add a pin.
                take_stamp     = 1'b1;
                wr_en          = 1'b1;
                wr_entry.page  = page_reg;
                wr_entry.stamp = stamp_reg;
                wr_entry.pins  = pins_inc;
                res_status     = ST_HIT;
                res_slot       = hit_idx_reg;
                res_pins       = pins_inc;
            end
            else if (occ_reg != CW'(SLOTS))
            begin
                // A free slot exists: take the lowest one.
                install  = 1'b1;
                inst_idx = free_idx_reg;
                occ_next = CW'(occ_reg + 1'b1);
            end
            else if (vic_found_reg)
            begin
                // Evict the oldest unpinned slot; a dirty victim is written back.
                install  = 1'b1;
                inst_idx = vic_idx_reg;
                if (dirty_reg[vic_idx_reg])
                begin
                    res_wb    = 1'b1;
                    res_wb_id = vic_entry_reg.page;
                end
            end
            else
            begin
                res_status = ST_PINNED;
            end

            if (install)
            begin
                take_stamp           = 1'b1;
                wr_en                = 1'b1;
                wr_idx               = inst_idx;
                wr_entry.page        = page_reg;
                wr_entry.stamp       = stamp_reg;
                wr_entry.pins        = PIN_W'(1);
                valid_next[inst_idx] = 1'b1;
                dirty_next[inst_idx] = 1'b0;
                res_status           = ST_MISS;
                res_slot             = inst_idx;
                res_fetch            = 1'b1;
                res_pins             = PIN_W'(1);
            end
        end
        else if (found_reg)
        begin
            res_status = ST_DONE;
            res_slot   = hit_idx_reg;
            res_pins   = hit_entry_reg.pins;
            case (func_reg)
                FN_UNPIN:
                begin
                    wr_en         = 1'b1;
                    wr_entry.pins = pins_dec;
                    res_pins      = pins_dec;
                end
                FN_DIRTY:
                begin
                    dirty_next[hit_idx_reg] = 1'b1;
                end
                FN_FLUSH:
                begin
                    dirty_next[hit_idx_reg] = 1'b0;
                    res_wb                  = 1'b1;
                    res_wb_id               = page_reg;
                end
                default:
                begin
                end
            endcase
        end

        // The slot takes the current stamp; the counter then moves on and stops at its top.
        if (take_stamp && (stamp_reg != STAMP_MAX))
            stamp_next = stamp_reg + 1'b1;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_cnt_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            stamp_reg      <= '0;
            occ_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (accept)
            begin
                issue_cnt_reg  <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                vic_found_reg  <= 1'b0;
            end
            else
            begin
                if (issue)
                    issue_cnt_reg <= CW'(issue_cnt_reg + 1'b1);
                found_reg      <= found_next;
                free_found_reg <= free_found_next;
                vic_found_reg  <= vic_found_next;
            end
            if (commit)
            begin
                valid_reg     <= valid_next;
                dirty_reg     <= dirty_next;
                stamp_reg     <= stamp_next;
                occ_reg       <= occ_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(req.func);
            page_reg <= req.page_id;
        end
        rd_idx_reg    <= rd_addr;
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
        free_idx_reg  <= free_idx_next;
        vic_idx_reg   <= vic_idx_next;
        vic_entry_reg <= vic_entry_next;
        if (commit)
        begin
            rsp_status_reg <= res_status;
            rsp_slot_reg   <= res_slot;
            rsp_fetch_reg  <= res_fetch;
            rsp_wb_reg     <= res_wb;
            rsp_wb_id_reg  <= res_wb_id;
            rsp_pins_reg   <= res_pins;
        end
    end

    // Slot memory: one registered read port for the scan, one write port for the decision.
    always_ff @(posedge clk)
    begin
        if (issue)
            rd_data_reg <= entry_mem[rd_addr];
        if (commit && wr_en)
            entry_mem[wr_idx] <= wr_entry;
    end

    // With more than sixteen slots only the low four bits of the slot number are shown.
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.slot_index      = INDEX_W'(rsp_slot_reg);
    assign rsp.fetch_valid     = rsp_fetch_reg;
    assign rsp.writeback_valid = rsp_wb_reg;
    assign rsp.writeback_id    = rsp_wb_id_reg;
    assign rsp.pins_now        = rsp_pins_reg;

endmodule

FILE: sv/lpd_checker.sv
// Port-level checks on the pinned page directory, bound to its top level.
`timescale 1ns / 1ps

module lpd_checker (
    input logic       clk,
    input logic       rst_n,
    lpd_req_if.sink   req,
    lpd_rsp_if.source rsp
);
    import lpd_pkg::*;

    // A result that is not taken holds still.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status) &&
                                    $stable(rsp.writeback_id) && $stable(rsp.pins_now))
        else $error("response changed while stalled");

    // The directory works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while the previous one is still in work");

    // A fetch comes only with an installed page, which holds exactly one pin.
    a_fetch_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.fetch_valid || rsp.status == ST_MISS) |->
            rsp.fetch_valid && rsp.status == ST_MISS && rsp.pins_now == 16'd1)
        else $error("fetch and miss status disagree");

    // Failed requests carry nothing else.
    a_empty_failure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_PINNED || rsp.status == ST_ABSENT) |->
            rsp.slot_index == '0 && rsp.pins_now == '0 &&
            !rsp.fetch_valid && !rsp.writeback_valid)
        else $error("failed request reports a slot, pins or transfers");

    // A write-back id is shown only with a write-back.
    a_writeback_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.writeback_valid |-> rsp.writeback_id == '0)
        else $error("write-back id without a write-back");

endmodule

bind lru_pinned_page_directory_top lpd_checker u_lpd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);
